/* rtl/rrq_pkg.sv */
// Shared types and codes for the resource request queue.
`default_nettype none

package rrq_pkg;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TAG_W   = 16;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [TAG_W-1:0]   tag_t;

	typedef enum logic [2:0] {
		ST_SUCCESS      = 3'd0,
		ST_INSUFFICIENT = 3'd1,
		ST_FULL         = 3'd2,
		ST_PENDING      = 3'd3,
		ST_EMPTY        = 3'd4
	} status_t;

	localparam logic FUNC_GET    = 1'b0;
	localparam logic FUNC_RESUME = 1'b1;

	localparam logic [1:0] REQ_SYNC    = 2'd0;
	localparam logic [1:0] REQ_PARTIAL = 2'd2;

	// one queued request
	typedef struct packed {
		count_t count;
		logic   partial;
		tag_t   tag;
	} entry_t;

endpackage

`default_nettype wire

/* rtl/resource_request_queue_unit.sv */
// Resource request admission queue: FIFO of pending requests with grant logic.
// Path: a taken word goes through the input register, then single-pass grant
//   logic into the result register; queue state updates along with it.
// Throughput: one word per cycle while the master side does not stall.
// Reset: arst_n clears valids, pointers and occupancy; queue entries stay
//   undefined, no clearing pass, so a word can be taken right after reset.
`default_nettype none

module resource_request_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] req_count, [17:16] rtype, [33:18] avail_count, [49:34] req_tag
	input  wire logic [55:0] s_tdata,
	// [0] func
	input  wire logic        s_tuser,
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] status, [18:3] granted_count, [34:19] resp_tag
	output logic [39:0]      m_tdata
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	// ---------------- input register ----------------
	logic                 valid_s1;
	logic                 func_s1;
	rrq_pkg::count_t      req_count_s1;
	logic [1:0]           rtype_s1;
	rrq_pkg::count_t      avail_s1;
	rrq_pkg::tag_t        req_tag_s1;

	// result register
	logic                 out_valid_q;
	rrq_pkg::status_t     out_status_q;
	rrq_pkg::count_t      out_grant_q;
	rrq_pkg::tag_t        out_tag_q;

	// queue control
	logic [PTR_W-1:0]     head_ptr_q;
	logic [PTR_W-1:0]     tail_ptr_q;
	logic [OCC_W-1:0]     occ_q;

	// entry storage, head entry held in a read register
	rrq_pkg::entry_t      mem_q [QUEUE_DEPTH];
	rrq_pkg::entry_t      head_q;

	logic                 advance;  // s1 moves into the result register
	logic                 fire;     // an item is processed this cycle

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1      <= s_tuser;
			req_count_s1 <= s_tdata[15:0];
			rtype_s1     <= s_tdata[17:16];
			avail_s1     <= s_tdata[33:18];
			req_tag_s1   <= s_tdata[49:34];
		end
	end

	// ---------------- grant decision ----------------
	rrq_pkg::status_t     status_c;
	rrq_pkg::count_t      grant_c;
	rrq_pkg::tag_t        tag_c;
	logic                 push_c;
	logic                 pop_c;
	logic                 upd_c;
	rrq_pkg::entry_t      push_entry_c;
	logic                 q_empty;
	logic                 q_full;

	assign q_empty = (occ_q == '0);
	assign q_full  = (occ_q == OCC_FULL);

	always_comb begin
		status_c     = rrq_pkg::ST_SUCCESS;
		grant_c      = '0;
		tag_c        = '0;
		push_c       = 1'b0;
		pop_c        = 1'b0;
		upd_c        = 1'b0;
		push_entry_c = '{count: req_count_s1, partial: 1'b0, tag: req_tag_s1};

		if (func_s1 == rrq_pkg::FUNC_GET) begin
			if (q_empty && (req_count_s1 <= avail_s1)) begin
				status_c = rrq_pkg::ST_SUCCESS;
				grant_c  = req_count_s1;
			end else if (rtype_s1 == rrq_pkg::REQ_SYNC) begin
				status_c = rrq_pkg::ST_INSUFFICIENT;
			end else if (q_full) begin
				status_c = rrq_pkg::ST_FULL;
			end else begin
				status_c = rrq_pkg::ST_PENDING;
				push_c   = 1'b1;
				// partial-ok on empty queue: hand out what is there, queue the rest
				if (rtype_s1 == rrq_pkg::REQ_PARTIAL && q_empty) begin
					grant_c              = avail_s1;
					push_entry_c.count   = req_count_s1 - avail_s1;
					push_entry_c.partial = 1'b1;
				end
			end
		end else begin
			if (q_empty) begin
				status_c = rrq_pkg::ST_EMPTY;
			end else begin
				tag_c = head_q.tag;
				if (head_q.count > avail_s1) begin
					if (head_q.partial) begin
						status_c = rrq_pkg::ST_PENDING;
						grant_c  = avail_s1;
						upd_c    = 1'b1;
					end else begin
						status_c = rrq_pkg::ST_INSUFFICIENT;
					end
				end else begin
					status_c = rrq_pkg::ST_SUCCESS;
					grant_c  = head_q.count;
					pop_c    = 1'b1;
				end
			end
		end
	end

	// ---------------- queue storage ----------------
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_addr;
	rrq_pkg::entry_t      wr_data;
	logic [PTR_W-1:0]     head_next;
	logic [PTR_W-1:0]     tail_next;
	logic [PTR_W-1:0]     rd_addr;

	assign head_next = (head_ptr_q == PTR_LAST) ? '0 : head_ptr_q + PTR_W'(1);
	assign tail_next = (tail_ptr_q == PTR_LAST) ? '0 : tail_ptr_q + PTR_W'(1);

	// one write port: push at tail, or rewrite head remainder on partial resume
	assign wr_en   = fire && (push_c || upd_c);
	assign wr_addr = push_c ? tail_ptr_q : head_ptr_q;
	assign wr_data = push_c ? push_entry_c
	                        : rrq_pkg::entry_t'{count: head_q.count - avail_s1,
	                                            partial: 1'b1, tag: head_q.tag};
	// read the entry that will be head after this cycle
	assign rd_addr = (fire && pop_c) ? head_next : head_ptr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// write-first forwarding keeps head_q equal to the stored head entry
		if (wr_en && (wr_addr == rd_addr)) begin
			head_q <= wr_data;
		end else begin
			head_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			occ_q      <= '0;
		end else if (fire) begin
			if (push_c) begin
				tail_ptr_q <= tail_next;
				occ_q      <= occ_q + OCC_W'(1);
			end else if (pop_c) begin
				head_ptr_q <= head_next;
				occ_q      <= occ_q - OCC_W'(1);
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= status_c;
			out_grant_q  <= grant_c;
			out_tag_q    <= tag_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_tag_q, out_grant_q, out_status_q};

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above queue depth");

	a_ptr_align: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == OCC_FULL) |-> head_ptr_q == tail_ptr_q)
		else $error("pointers disagree with occupancy");

	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && push_c) |=> occ_q == $past(occ_q) + OCC_W'(1))
		else $error("push did not grow queue");

	a_pop_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && pop_c) |=> occ_q == $past(occ_q) - OCC_W'(1))
		else $error("pop did not shrink queue");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled word dropped from input register");
`endif

endmodule

`default_nettype wire

/* tb/tb_resource_request_queue_unit.sv */
// Self-checking testbench for the resource request queue unit.
`timescale 1ns / 1ps

module tb_resource_request_queue_unit;

	localparam int QDEPTH = 16;
	localparam int RAND_WORDS = 1615;   // random words after the probe table
	localparam int CALM_TAIL = 300;     // last words run with no idling on either side
	localparam int HOLD_CYCLES = 80;    // one long receiver stall, backs up the slave side
	localparam int DRAIN_CYCLES = 4;    // idle margin after the last owed result

	// request types the package does not name
	localparam logic [1:0] REQ_ASYNC = 2'd1;
	localparam logic [1:0] REQ_SPARE = 2'd3;   // unused code, acts as async

	// one result word, the m_tdata fields (packed here in reverse order)
	typedef struct packed {
		rrq_pkg::status_t status;
		rrq_pkg::count_t  granted;
		rrq_pkg::tag_t    tag;
	} grant_t;

	// per accepted word: a typed-in result overrides the predictor's
	typedef struct packed {
		logic   typed;
		grant_t res;
	} word_note_t;

	// probe table row; reps repeats the same word
	typedef struct {
		logic            func;
		rrq_pkg::count_t cnt;
		logic [1:0]      rtype;
		rrq_pkg::count_t avail;
		rrq_pkg::tag_t   tag;
		int              reps;
		word_note_t      note;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	resource_request_queue_unit #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// mirror of the queue: remaining count, partial flag and tag per slot
	rrq_pkg::count_t slot_count[QDEPTH];
	logic            slot_partial[QDEPTH];
	rrq_pkg::tag_t   slot_tag[QDEPTH];
	int     rd_idx = 0;
	int     wr_idx = 0;
	int     fill_level = 0;

	grant_t     due_results[$];   // results owed by the block, oldest first
	word_note_t word_notes[$];    // one per offered word, popped on accept
	probe_t     probe_rows[$];

	int  mismatches = 0;
	int  words_in = 0;
	int  results_seen = 0;
	bit  calm = 1'b0;       // set for the tail of the run: no idling
	bit  squeezed = 1'b0;   // long stall already done
	grant_t oldest;

	// Grant decision for one word; updates the mirrored queue the way the block should.
	function automatic grant_t admit_word(input logic func, input rrq_pkg::count_t want,
			input logic [1:0] rtype, input rrq_pkg::count_t avail,
			input rrq_pkg::tag_t tag);
		grant_t r;
		r.status = rrq_pkg::ST_SUCCESS;
		r.granted = '0;
		r.tag = '0;
		if (func == rrq_pkg::FUNC_GET) begin
			if (fill_level == 0 && want <= avail) begin
				r.granted = want;
			end else if (rtype == rrq_pkg::REQ_SYNC) begin
				// sync never waits, even when the count would fit behind the queue
				r.status = rrq_pkg::ST_INSUFFICIENT;
			end else if (fill_level >= QDEPTH) begin
				r.status = rrq_pkg::ST_FULL;
			end else begin
				r.status = rrq_pkg::ST_PENDING;
				if (rtype == rrq_pkg::REQ_PARTIAL && fill_level == 0) begin
					// partial-ok on an empty queue: take what is there, queue the rest
					slot_count[wr_idx] = want - avail;
					slot_partial[wr_idx] = 1'b1;
					r.granted = avail;
				end else begin
					slot_count[wr_idx] = want;
					slot_partial[wr_idx] = 1'b0;
				end
				slot_tag[wr_idx] = tag;
				wr_idx = (wr_idx + 1) % QDEPTH;
				fill_level++;
			end
		end else if (fill_level == 0) begin
			r.status = rrq_pkg::ST_EMPTY;
		end else begin
			r.tag = slot_tag[rd_idx];
			if (slot_count[rd_idx] > avail) begin
				if (!slot_partial[rd_idx]) begin
					r.status = rrq_pkg::ST_INSUFFICIENT;
				end else begin
					// head stays, shrunk by what was handed out
					r.status = rrq_pkg::ST_PENDING;
					r.granted = avail;
					slot_count[rd_idx] = slot_count[rd_idx] - avail;
				end
			end else begin
				r.granted = slot_count[rd_idx];
				rd_idx = (rd_idx + 1) % QDEPTH;
				fill_level--;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
			results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic add_probe(input logic func, input rrq_pkg::count_t cnt,
			input logic [1:0] rtype, input rrq_pkg::count_t avail,
			input rrq_pkg::tag_t tag, input int reps, input logic typed,
			input rrq_pkg::status_t st, input rrq_pkg::count_t granted,
			input rrq_pkg::tag_t rtag);
		probe_t p;
		p.func = func;
		p.cnt = cnt;
		p.rtype = rtype;
		p.avail = avail;
		p.tag = tag;
		p.reps = reps;
		p.note.typed = typed;
		p.note.res.status = st;
		p.note.res.granted = granted;
		p.note.res.tag = rtag;
		probe_rows.push_back(p);
	endtask

	// Offer one word, maybe after an idle burst, and return at the edge that takes it.
	task automatic send_word(input logic func, input rrq_pkg::count_t cnt,
			input logic [1:0] rtype, input rrq_pkg::count_t avail,
			input rrq_pkg::tag_t tag, input word_note_t note);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		word_notes.push_back(note);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {6'b0, tag, avail, rtype, cnt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Slave-side accept: run the prediction in acceptance order.
	always @(posedge clk) begin
		word_note_t n;
		grant_t g;
		if (arst_n && s_tvalid && s_tready) begin
			n = word_notes.pop_front();
			g = admit_word(s_tuser, s_tdata[15:0], s_tdata[17:16], s_tdata[33:18],
				s_tdata[49:34]);
			due_results.push_back(n.typed ? n.res : g);
			words_in++;
		end
	end

	// Master-side accept: compare field by field with the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				flag_mismatch("word with no result due", m_tdata, '0);
			end else begin
				oldest = due_results.pop_front();
				if (m_tdata[2:0] != oldest.status)
					flag_mismatch("status", 40'(m_tdata[2:0]), 40'(oldest.status));
				if (m_tdata[18:3] != oldest.granted)
					flag_mismatch("granted_count", 40'(m_tdata[18:3]),
						40'(oldest.granted));
				if (m_tdata[34:19] != oldest.tag)
					flag_mismatch("resp_tag", 40'(m_tdata[34:19]), 40'(oldest.tag));
			end
			results_seen++;
		end
	end

	// Receiver: short random stalls, one long hold once traffic is flowing.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!squeezed && words_in >= 500) begin
				squeezed = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Sender: reset, probe table, random traffic, then drain and verdict.
	initial begin
		int              total;
		int              sent;
		int              phase_left;
		int              roll;
		int              kind;
		bit              filling;
		logic            f;
		rrq_pkg::count_t c;
		rrq_pkg::count_t a;
		logic [1:0]      rt;
		rrq_pkg::tag_t   tg;
		word_note_t      blank;

		blank = '0;
		total = RAND_WORDS;
		sent = 0;
		filling = 1'b1;
		phase_left = 20;

		// empty-queue cases: resume on nothing, zero count, extremes, sync refusal, async queued
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'd0, 1, 1'b1,
			rrq_pkg::ST_EMPTY, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'hFFFF, 1, 1'b1,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'hFFFF, rrq_pkg::REQ_SYNC, 16'hFFFF, 16'd0, 1, 1'b1,
			rrq_pkg::ST_SUCCESS, 16'hFFFF, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd5, rrq_pkg::REQ_SYNC, 16'd4, 16'd9, 1, 1'b1,
			rrq_pkg::ST_INSUFFICIENT, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd100, REQ_ASYNC, 16'd50, 16'hA5A5, 1, 1'b1,
			rrq_pkg::ST_PENDING, 16'd0, 16'd0);
		// sync with something queued is refused even though it would fit
		add_probe(rrq_pkg::FUNC_GET, 16'd1, rrq_pkg::REQ_SYNC, 16'd100, 16'd3, 1, 1'b1,
			rrq_pkg::ST_INSUFFICIENT, 16'd0, 16'd0);
		// partial-ok behind a queue is queued whole, spare code acts as async, zero count
		add_probe(rrq_pkg::FUNC_GET, 16'd10, rrq_pkg::REQ_PARTIAL, 16'd0, 16'h1234, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd0, REQ_SPARE, 16'hFFFF, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		// resume refused by one, then taken exactly, then the rest of the queue
		add_probe(rrq_pkg::FUNC_RESUME, 16'hFFFF, rrq_pkg::REQ_SYNC, 16'd99, 16'hFFFF, 1,
			1'b0, rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_PARTIAL, 16'd100, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'hFFFF, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'd0, 1, 1'b1,
			rrq_pkg::ST_EMPTY, 16'd0, 16'd0);
		// partial grant on empty queue, then partial resumes of the remainder
		add_probe(rrq_pkg::FUNC_GET, 16'hFFFF, rrq_pkg::REQ_PARTIAL, 16'd1, 16'h5A5A, 1,
			1'b1, rrq_pkg::ST_PENDING, 16'd1, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'h1000, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd0, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'hFFFF, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		// fill to depth, then full refusals; sync is refused before the full check
		add_probe(rrq_pkg::FUNC_GET, 16'd7, REQ_ASYNC, 16'd0, 16'h0F0F, QDEPTH, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd1, REQ_ASYNC, 16'd0, 16'd1, 1, 1'b1,
			rrq_pkg::ST_FULL, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd1, rrq_pkg::REQ_PARTIAL, 16'd0, 16'd2, 1, 1'b1,
			rrq_pkg::ST_FULL, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_GET, 16'd0, rrq_pkg::REQ_SYNC, 16'hFFFF, 16'd3, 1, 1'b1,
			rrq_pkg::ST_INSUFFICIENT, 16'd0, 16'd0);
		add_probe(rrq_pkg::FUNC_RESUME, 16'd0, rrq_pkg::REQ_SYNC, 16'd7, 16'd0, 1, 1'b0,
			rrq_pkg::ST_SUCCESS, 16'd0, 16'd0);

		foreach (probe_rows[i]) total += probe_rows[i].reps;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probe_rows[i]) begin
			repeat (probe_rows[i].reps) begin
				send_word(probe_rows[i].func, probe_rows[i].cnt, probe_rows[i].rtype,
					probe_rows[i].avail, probe_rows[i].tag, probe_rows[i].note);
				sent++;
			end
		end

		// Random part: alternating fill and drain phases so the queue swings
		// between empty and full; a tenth of the words are unshaped noise.
		repeat (RAND_WORDS) begin
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(8, 40);
			end
			phase_left--;
			calm = (sent >= total - CALM_TAIL);
			roll = $urandom_range(0, 99);
			tg = rrq_pkg::tag_t'($urandom);
			if (roll < 10) begin
				f = logic'($urandom_range(0, 1));
				c = rrq_pkg::count_t'($urandom);
				a = rrq_pkg::count_t'($urandom);
				rt = 2'($urandom);
			end else begin
				f = (roll < (filling ? 30 : 80)) ? rrq_pkg::FUNC_RESUME : rrq_pkg::FUNC_GET;
				c = rrq_pkg::count_t'($urandom_range(0, 300));
				a = rrq_pkg::count_t'($urandom_range(0, filling ? 150 : 400));
				kind = $urandom_range(0, 9);
				rt = (kind == 0) ? rrq_pkg::REQ_SYNC : (kind < 5) ? REQ_ASYNC :
					(kind < 9) ? rrq_pkg::REQ_PARTIAL : REQ_SPARE;
			end
			send_word(f, c, rt, a, tg, blank);
			sent++;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
